FILE: sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared codes, sizes and interface types of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

	// Controller kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_MBC1 = 3'd1;
	localparam logic [2:0] KIND_MBC2 = 3'd2;
	localparam logic [2:0] KIND_MBC3 = 3'd3;
	localparam logic [2:0] KIND_MBC5 = 3'd4;

	// Item actions
	localparam logic [1:0] ACT_CTRL = 2'd0;
	localparam logic [1:0] ACT_RD   = 2'd1;
	localparam logic [1:0] ACT_WR   = 2'd2;
	localparam logic [1:0] ACT_TICK = 2'd3;

	// Clock register select codes
	localparam logic [2:0] CSEL_NONE = 3'd0;
	localparam logic [2:0] CSEL_SEC  = 3'd1;
	localparam logic [2:0] CSEL_MIN  = 3'd2;
	localparam logic [2:0] CSEL_HOUR = 3'd3;
	localparam logic [2:0] CSEL_DAYL = 3'd4;
	localparam logic [2:0] CSEL_DAYH = 3'd5;

	// Configuration register map (index is paddr[2])
	localparam int        PADDR_W     = 3;
	localparam logic      REG_KIND    = 1'b0;
	localparam logic      REG_CLKPRES = 1'b1;

	// MBC2 nibble RAM
	localparam int NRAM_DEPTH = 512;
	localparam int NRAM_AW    = $clog2(NRAM_DEPTH);

	// Nibble RAM port request
	typedef struct packed {
		logic               rd_en;
		logic [NRAM_AW-1:0] rd_addr;
		logic               wr_en;
		logic [NRAM_AW-1:0] wr_addr;
		logic [3:0]         wr_data;
	} nram_req_t;

	// Commands to the real-time clock
	typedef struct packed {
		logic       tick;
		logic       latch;
		logic       wr;
		logic [2:0] sel;
		logic [7:0] data;
	} rtc_cmd_t;

endpackage

FILE: sv/cbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cbc_cfg_regs
// APB register file: controller kind and clock-present flag.
// ----------------------------------------------------------------------------
module cbc_cfg_regs import cbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [2:0]         kind,
	output logic               clock_present
);

	logic [2:0] kind_q;
	logic       clkp_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			clkp_q <= 1'b0;
		end else if (wr) begin
			case (paddr[2])
				REG_KIND:    kind_q <= pwdata[2:0];
				REG_CLKPRES: clkp_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			REG_KIND:    prdata = {29'd0, kind_q};
			REG_CLKPRES: prdata = {31'd0, clkp_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign kind          = kind_q;
	assign clock_present = clkp_q;

	a_kind_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && paddr[2] == REG_KIND) |=> kind_q == $past(pwdata[2:0]))
		else $error("kind register write lost");
	a_clkp_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && paddr[2] == REG_CLKPRES) |=> clkp_q == $past(pwdata[0]))
		else $error("clock-present register write lost");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!wr |=> $stable(kind_q) && $stable(clkp_q))
		else $error("config changed without a write transaction");

endmodule

FILE: sv/cbc_nibble_ram.sv
// ----------------------------------------------------------------------------
// cbc_nibble_ram
// 512x4 MBC2 RAM with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module cbc_nibble_ram import cbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  nram_req_t req,
	output logic [3:0] rd_data,
	output logic      busy
);

	logic [3:0]         mem [NRAM_DEPTH];
	logic [3:0]         rd_data_q;
	logic [NRAM_AW-1:0] clr_addr_q;
	logic               clearing_q;
	logic               clr_last;

	assign clr_last = (clr_addr_q == NRAM_AW'(NRAM_DEPTH - 1));

	// Clear sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_last) clearing_q <= 1'b0;
		end
	end

	// Array write port and registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= 4'd0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clearing_q;

	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.wr_en && !req.rd_en)
		else $error("RAM access during clearing sweep");
	a_clr_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> clr_addr_q == '0)
		else $error("clearing sweep ended early");
	a_clr_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing sweep restarted");

endmodule

FILE: sv/cbc_rtc.sv
// ----------------------------------------------------------------------------
// cbc_rtc
// MBC3 real-time clock: live counters, latched copy, register writes, ticks.
// ----------------------------------------------------------------------------
module cbc_rtc import cbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rtc_cmd_t   cmd,
	output logic [7:0] latch_rd
);

	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [8:0] days_q;
	logic       halt_q;
	logic       carry_q;
	logic [7:0] latched_q [5];

	// Tick carry chain; fields may hold out-of-range written values
	logic [6:0] sec_inc;
	logic       c_sec;
	logic [5:0] sec_nx;
	logic [6:0] min_inc;
	logic       c_min;
	logic [5:0] min_nx;
	logic [5:0] hour_inc;
	logic       c_hour;
	logic [4:0] hour_nx;
	logic [9:0] days_inc;

	always_comb begin
		sec_inc  = {1'b0, sec_q} + 7'd1;
		c_sec    = (sec_inc >= 7'd60);
		sec_nx   = c_sec ? 6'(sec_inc - 7'd60) : sec_inc[5:0];
		min_inc  = {1'b0, min_q} + {6'd0, c_sec};
		c_min    = (min_inc >= 7'd60);
		min_nx   = c_min ? 6'(min_inc - 7'd60) : min_inc[5:0];
		hour_inc = {1'b0, hour_q} + {5'd0, c_min};
		c_hour   = (hour_inc >= 6'd24);
		hour_nx  = c_hour ? 5'(hour_inc - 6'd24) : hour_inc[4:0];
		days_inc = {1'b0, days_q} + {9'd0, c_hour};
	end

	// Live clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			days_q  <= '0;
			halt_q  <= 1'b0;
			carry_q <= 1'b0;
		end else if (cmd.wr) begin
			case (cmd.sel)
				CSEL_SEC:  sec_q  <= cmd.data[5:0];
				CSEL_MIN:  min_q  <= cmd.data[5:0];
				CSEL_HOUR: hour_q <= cmd.data[4:0];
				CSEL_DAYL: days_q[7:0] <= cmd.data;
				CSEL_DAYH: begin
					days_q[8] <= cmd.data[0];
					halt_q    <= cmd.data[6];
					carry_q   <= cmd.data[7];
				end
				default: ;
			endcase
		end else if (cmd.tick && !halt_q) begin
			sec_q  <= sec_nx;
			min_q  <= min_nx;
			hour_q <= hour_nx;
			days_q <= days_inc[8:0];
			if (days_inc[9]) carry_q <= 1'b1;
		end
	end

	// Latched copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) latched_q[i] <= '0;
		end else if (cmd.latch) begin
			latched_q[0] <= {2'd0, sec_q};
			latched_q[1] <= {2'd0, min_q};
			latched_q[2] <= {3'd0, hour_q};
			latched_q[3] <= days_q[7:0];
			latched_q[4] <= {carry_q, halt_q, 5'd0, days_q[8]};
		end
	end

	// Latched register read
	always_comb begin
		case (cmd.sel)
			CSEL_SEC:  latch_rd = latched_q[0];
			CSEL_MIN:  latch_rd = latched_q[1];
			CSEL_HOUR: latch_rd = latched_q[2];
			CSEL_DAYL: latch_rd = latched_q[3];
			CSEL_DAYH: latch_rd = latched_q[4];
			default:   latch_rd = 8'd0;
		endcase
	end

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick && !cmd.wr && halt_q) |=> $stable(sec_q) && $stable(days_q))
		else $error("clock advanced while halted");
	a_tick_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick && !cmd.wr && !halt_q) |=> sec_q < 6'd60 && min_q < 6'd60 && hour_q < 5'd24)
		else $error("tick left clock fields out of range");
	a_carry_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(carry_q && !(cmd.wr && cmd.sel == CSEL_DAYH)) |=> carry_q)
		else $error("day carry cleared without day-high write");

endmodule

FILE: sv/cartridge_bank_controller_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Pipeline: an input register and then a result register lie between a request
// transaction and its response; a held result register stalls the input stage.
// Throughput: one transaction per cycle while the response side keeps up and no
// clearing sweep runs; nibble RAM read issued at accept, with write forwarding.
// Reset: all bank and clock state cleared; the 512-entry nibble RAM is then
// cleared by a sweep during which req_ready stays low.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_core import cbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         action,
	input  logic [15:0]        addr,
	input  logic [7:0]         data,
	// response
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               handled,
	output logic [7:0]         read_data,
	output logic [8:0]         rom_bank_out,
	output logic [3:0]         ram_bank_out,
	output logic               ram_mapped
);

	localparam logic [15:0] ADDR_ENA_LAST = 16'h1fff;
	localparam logic [15:0] ADDR_ROM_LAST = 16'h3fff;
	localparam logic [15:0] ADDR_LOW_LAST = 16'h2fff;
	localparam logic [15:0] ADDR_RAM_LAST = 16'h5fff;
	localparam logic [15:0] ADDR_CTL_LAST = 16'h7fff;

	logic [2:0] kind;
	logic       clock_present;
	logic       nram_busy;
	logic [3:0] nram_rd;
	nram_req_t  nram_req;
	rtc_cmd_t   rtc_cmd;
	logic [7:0] latch_rd;

	// Bank state
	logic       ram_en_q;
	logic [8:0] rom_bank_q;
	logic [3:0] ram_bank_q;
	logic [2:0] csel_q;
	logic [7:0] latch_prev_q;

	// Input stage
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        fwd_hit_s1;
	logic [3:0]  fwd_data_s1;

	logic rsp_valid_q;
	logic s1_fire;
	logic accept;

	// Next state and result
	logic       ram_en_nx;
	logic [8:0] rom_bank_nx;
	logic [3:0] ram_bank_nx;
	logic [2:0] csel_nx;
	logic [7:0] latch_prev_nx;
	logic       handled_nx;
	logic [7:0] rd_nx;
	logic [3:0] nibble;

	cbc_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.kind          (kind),
		.clock_present (clock_present)
	);

	cbc_nibble_ram u_nram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (nram_req),
		.rd_data (nram_rd),
		.busy    (nram_busy)
	);

	cbc_rtc u_rtc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rtc_cmd),
		.latch_rd (latch_rd)
	);

	// Handshake
	assign s1_fire   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !nram_busy && (!valid_s1 || s1_fire);
	assign accept    = req_valid && req_ready;

	// Nibble RAM port: read at accept, write when the stage-1 transaction commits
	always_comb begin
		nram_req.rd_en   = accept;
		nram_req.rd_addr = addr[NRAM_AW-1:0];
		nram_req.wr_en   = s1_fire && action_s1 == ACT_WR && ram_en_q && kind == KIND_MBC2;
		nram_req.wr_addr = addr_s1[NRAM_AW-1:0];
		nram_req.wr_data = data_s1[3:0];
	end

	assign nibble = fwd_hit_s1 ? fwd_data_s1 : nram_rd;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= action;
			addr_s1     <= addr;
			data_s1     <= data;
			fwd_hit_s1  <= nram_req.wr_en && nram_req.wr_addr == addr[NRAM_AW-1:0];
			fwd_data_s1 <= nram_req.wr_data;
		end
	end

	// Transaction decode and bank register update
	always_comb begin
		ram_en_nx     = ram_en_q;
		rom_bank_nx   = rom_bank_q;
		ram_bank_nx   = ram_bank_q;
		csel_nx       = csel_q;
		latch_prev_nx = latch_prev_q;
		handled_nx    = 1'b0;
		rd_nx         = 8'd0;
		rtc_cmd       = '0;
		rtc_cmd.sel   = csel_q;
		rtc_cmd.data  = data_s1;

		case (action_s1)
			ACT_CTRL: begin
				case (kind)
					KIND_MBC1: begin
						handled_nx = (addr_s1 <= ADDR_CTL_LAST);
						if (addr_s1 <= ADDR_ENA_LAST) begin
							ram_en_nx = (data_s1[3:0] == 4'ha);
						end else if (addr_s1 <= ADDR_ROM_LAST) begin
							rom_bank_nx = {4'd0, data_s1[4:0]};
						end else if (addr_s1 <= ADDR_RAM_LAST) begin
							ram_bank_nx = {2'd0, data_s1[1:0]};
						end
					end
					KIND_MBC2: begin
						handled_nx = (addr_s1 <= ADDR_ROM_LAST);
						if (addr_s1 <= ADDR_ROM_LAST) begin
							if (!addr_s1[8]) ram_en_nx = (data_s1[3:0] == 4'ha);
							else rom_bank_nx = {5'd0, data_s1[3:0]};
						end
					end
					KIND_MBC3: begin
						handled_nx = (addr_s1 <= ADDR_CTL_LAST);
						if (addr_s1 <= ADDR_ENA_LAST) begin
							ram_en_nx = (data_s1[3:0] == 4'ha);
						end else if (addr_s1 <= ADDR_ROM_LAST) begin
							rom_bank_nx = {2'd0, data_s1[6:0]};
						end else if (addr_s1 <= ADDR_RAM_LAST) begin
							if (data_s1 <= 8'h03) begin
								ram_bank_nx = data_s1[3:0];
								csel_nx     = CSEL_NONE;
							end else if (data_s1 >= 8'h08 && data_s1 <= 8'h0c) begin
								csel_nx = 3'(data_s1 - 8'd7);
							end
						end else if (addr_s1 <= ADDR_CTL_LAST) begin
							rtc_cmd.latch = (latch_prev_q == 8'd0) && (data_s1 == 8'd1);
							latch_prev_nx = data_s1;
						end
					end
					KIND_MBC5: begin
						handled_nx = (addr_s1 <= ADDR_RAM_LAST);
						if (addr_s1 <= ADDR_ENA_LAST) begin
							ram_en_nx = (data_s1[3:0] == 4'ha);
						end else if (addr_s1 <= ADDR_LOW_LAST) begin
							rom_bank_nx = {rom_bank_q[8], data_s1};
						end else if (addr_s1 <= ADDR_ROM_LAST) begin
							rom_bank_nx = {data_s1[0], rom_bank_q[7:0]};
						end else if (addr_s1 <= ADDR_RAM_LAST) begin
							ram_bank_nx = data_s1[3:0];
						end
					end
					default: ;
				endcase
			end
			ACT_RD: begin
				if (ram_en_q && kind == KIND_MBC2) begin
					rd_nx      = {4'hf, nibble};
					handled_nx = 1'b1;
				end else if (ram_en_q && kind == KIND_MBC3 && csel_q != CSEL_NONE) begin
					rd_nx      = latch_rd;
					handled_nx = 1'b1;
				end
			end
			ACT_WR: begin
				if (ram_en_q && kind == KIND_MBC2) begin
					handled_nx = 1'b1;
				end else if (ram_en_q && kind == KIND_MBC3) begin
					rtc_cmd.wr = 1'b1;
					handled_nx = (csel_q >= CSEL_SEC && csel_q <= CSEL_DAYH);
				end
			end
			ACT_TICK: begin
				rtc_cmd.tick = (kind == KIND_MBC3) && clock_present;
			end
			default: ;
		endcase

		// clock commands only take effect when the transaction commits
		rtc_cmd.tick  = rtc_cmd.tick && s1_fire;
		rtc_cmd.latch = rtc_cmd.latch && s1_fire;
		rtc_cmd.wr    = rtc_cmd.wr && s1_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q     <= 1'b0;
			rom_bank_q   <= '0;
			ram_bank_q   <= '0;
			csel_q       <= CSEL_NONE;
			latch_prev_q <= '0;
		end else if (s1_fire) begin
			ram_en_q     <= ram_en_nx;
			rom_bank_q   <= rom_bank_nx;
			ram_bank_q   <= ram_bank_nx;
			csel_q       <= csel_nx;
			latch_prev_q <= latch_prev_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			handled      <= handled_nx;
			read_data    <= rd_nx;
			rom_bank_out <= (kind != KIND_MBC5 && rom_bank_nx == 9'd0) ? 9'd1 : rom_bank_nx;
			ram_bank_out <= ram_bank_nx;
			ram_mapped   <= ram_en_nx && (csel_nx == CSEL_NONE);
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		nram_busy |-> !req_ready)
		else $error("request accepted during RAM clearing");
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |-> !req_ready)
		else $error("input stage overwritten while stalled");
	a_csel_range: assert property (@(posedge clk) disable iff (!arst_n)
		csel_q <= CSEL_DAYH)
		else $error("clock select out of range");
	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid_q)
		else $error("committed transaction produced no response");

endmodule

FILE: tb/sv/cbc_rsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_rsp_checker
// Watches the configuration port and both transaction channels of the
// cartridge bank controller. It keeps its own copy of the mapper state,
// predicts the response of every request transaction, and compares each
// response transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cbc_rsp_checker import cbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	// request channel
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [1:0]         action,
	input  logic [15:0]        addr,
	input  logic [7:0]         data,
	// response channel
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic               handled,
	input  logic [7:0]         read_data,
	input  logic [8:0]         rom_bank_out,
	input  logic [3:0]         ram_bank_out,
	input  logic               ram_mapped,
	// status to the top
	output int                 err_count,
	output int                 rsp_outstanding
);

	typedef struct packed {
		logic       handled;
		logic [7:0] read_data;
		logic [8:0] rom_num;
		logic [3:0] ram_num;
		logic       ram_mapped;
	} mapper_rsp_t;

	// Mirrored configuration
	logic [2:0] cfg_kind;
	logic       cfg_clock;

	// Mirrored bank, clock and RAM state
	logic       ram_en;
	logic [8:0] rom_num;
	logic [3:0] ram_num;
	logic [2:0] clk_sel;
	logic [7:0] latch_last;
	logic [5:0] rtc_sec;
	logic [5:0] rtc_min;
	logic [4:0] rtc_hour;
	logic [8:0] rtc_day;
	logic       rtc_halt;
	logic       rtc_carry;
	logic [7:0] rtc_snap [5];
	logic [3:0] nibble_mem [NRAM_DEPTH];

	// Responses predicted but not yet seen, oldest first
	mapper_rsp_t mapper_rsp_q [$];

	function automatic logic enable_code(input logic [7:0] d);
		return d[3:0] == 4'hA;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// Apply one bus access to the mirrored state and build its response
	task automatic mapper_access(input logic [1:0] act, input logic [15:0] a,
			input logic [7:0] d, output mapper_rsp_t r);
		logic        hit;
		logic [7:0]  rdata;
		int unsigned secs;
		int unsigned days;
		hit = 1'b0;
		rdata = 8'h00;
		case (act)
		ACT_CTRL: begin
			case (cfg_kind)
			KIND_MBC1: begin
				hit = (a <= 16'h7FFF);
				if (a <= 16'h1FFF) ram_en = enable_code(d);
				else if (a <= 16'h3FFF) rom_num = {4'b0, d[4:0]};
				else if (a <= 16'h5FFF) ram_num = {2'b0, d[1:0]};
			end
			KIND_MBC2: begin
				hit = (a <= 16'h3FFF);
				if (hit && !a[8]) ram_en = enable_code(d);
				else if (hit) rom_num = {5'b0, d[3:0]};
			end
			KIND_MBC3: begin
				hit = (a <= 16'h7FFF);
				if (a <= 16'h1FFF) begin
					ram_en = enable_code(d);
				end else if (a <= 16'h3FFF) begin
					rom_num = {2'b0, d[6:0]};
				end else if (a <= 16'h5FFF) begin
					if (d <= 8'h03) begin
						ram_num = d[3:0];
						clk_sel = CSEL_NONE;
					end else if (d >= 8'h08 && d <= 8'h0C) begin
						clk_sel = 3'(d - 8'h07);
					end
				end else if (hit) begin
					// a 0 then 1 sequence snapshots the live clock
					if (latch_last == 8'h00 && d == 8'h01) begin
						rtc_snap[0] = {2'b0, rtc_sec};
						rtc_snap[1] = {2'b0, rtc_min};
						rtc_snap[2] = {3'b0, rtc_hour};
						rtc_snap[3] = rtc_day[7:0];
						rtc_snap[4] = {rtc_carry, rtc_halt, 5'b0, rtc_day[8]};
					end
					latch_last = d;
				end
			end
			KIND_MBC5: begin
				hit = (a <= 16'h5FFF);
				if (a <= 16'h1FFF) ram_en = enable_code(d);
				else if (a <= 16'h2FFF) rom_num[7:0] = d;
				else if (a <= 16'h3FFF) rom_num[8] = d[0];
				else if (hit) ram_num = d[3:0];
			end
			default: ;
			endcase
		end
		ACT_RD: begin
			if (ram_en && cfg_kind == KIND_MBC2) begin
				hit = 1'b1;
				rdata = {4'hF, nibble_mem[a[8:0]]};
			end else if (ram_en && cfg_kind == KIND_MBC3 && clk_sel != CSEL_NONE) begin
				hit = 1'b1;
				rdata = rtc_snap[clk_sel - CSEL_SEC];
			end
		end
		ACT_WR: begin
			if (ram_en && cfg_kind == KIND_MBC2) begin
				hit = 1'b1;
				nibble_mem[a[8:0]] = d[3:0];
			end else if (ram_en && cfg_kind == KIND_MBC3) begin
				// clock register writes go to the live clock
				hit = (clk_sel != CSEL_NONE);
				case (clk_sel)
				CSEL_SEC:  rtc_sec = d[5:0];
				CSEL_MIN:  rtc_min = d[5:0];
				CSEL_HOUR: rtc_hour = d[4:0];
				CSEL_DAYL: rtc_day[7:0] = d;
				CSEL_DAYH: begin
					rtc_day[8] = d[0];
					rtc_halt = d[6];
					rtc_carry = d[7];
				end
				default: ;
				endcase
			end
		end
		default: begin
			// one second; oversized fields fold into the next one up
			if (cfg_kind == KIND_MBC3 && cfg_clock && !rtc_halt) begin
				secs = 32'(rtc_hour) * 3600 + 32'(rtc_min) * 60 + 32'(rtc_sec) + 1;
				days = 32'(rtc_day) + secs / 86400;
				secs = secs % 86400;
				rtc_hour = 5'(secs / 3600);
				rtc_min = 6'((secs / 60) % 60);
				rtc_sec = 6'(secs % 60);
				if (days > 511) rtc_carry = 1'b1;
				rtc_day = 9'(days);
			end
		end
		endcase
		r.handled = hit;
		r.read_data = rdata;
		r.rom_num = (cfg_kind != KIND_MBC5 && rom_num == 9'd0) ? 9'd1 : rom_num;
		r.ram_num = ram_num;
		r.ram_mapped = ram_en && (clk_sel == CSEL_NONE);
	endtask

	// Snoop configuration and transactions; predict and compare
	always @(posedge clk or negedge arst_n) begin : watch
		mapper_rsp_t fresh;
		mapper_rsp_t oldest;
		if (!arst_n) begin
			cfg_kind = KIND_NONE;
			cfg_clock = 1'b0;
			ram_en = 1'b0;
			rom_num = '0;
			ram_num = '0;
			clk_sel = CSEL_NONE;
			latch_last = '0;
			rtc_sec = '0;
			rtc_min = '0;
			rtc_hour = '0;
			rtc_day = '0;
			rtc_halt = 1'b0;
			rtc_carry = 1'b0;
			for (int i = 0; i < 5; i++) rtc_snap[i] = '0;
			for (int i = 0; i < NRAM_DEPTH; i++) nibble_mem[i] = '0;
			mapper_rsp_q.delete();
			err_count = 0;
			rsp_outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_KIND) cfg_kind = pwdata[2:0];
				else cfg_clock = pwdata[0];
			end
			if (req_valid && req_ready) begin
				mapper_access(action, addr, data, fresh);
				mapper_rsp_q.push_back(fresh);
			end
			if (rsp_valid && rsp_ready) begin
				if (mapper_rsp_q.size() == 0) begin
					$error("response transaction with no request outstanding");
					err_count++;
				end else begin
					oldest = mapper_rsp_q.pop_front();
					check_field("handled", oldest.handled, handled);
					check_field("read_data", oldest.read_data, read_data);
					check_field("rom_bank_out", oldest.rom_num, rom_bank_out);
					check_field("ram_bank_out", oldest.ram_num, ram_bank_out);
					check_field("ram_mapped", oldest.ram_mapped, ram_mapped);
				end
			end
			rsp_outstanding = mapper_rsp_q.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the cartridge bank controller: a directed pass over the MBC3,
// MBC5 and MBC2 mapper kinds, a reserved kind, the clock rollover and latch,
// then random bus traffic over several controller settings, including MBC1,
// with random idling on both channels. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench import cbc_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AFTER_RSPS = 200;
	localparam int N_PHASES = 9;

	// Kinds with no meaning; they act as no controller
	localparam logic [2:0] KIND_RSVD_LO = 3'd5;
	localparam logic [2:0] KIND_RSVD_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid;
	logic               req_ready;
	logic [1:0]         action;
	logic [15:0]        addr;
	logic [7:0]         data;
	logic               rsp_valid;
	logic               rsp_ready;
	logic               handled;
	logic [7:0]         read_data;
	logic [8:0]         rom_bank_out;
	logic [3:0]         ram_bank_out;
	logic               ram_mapped;

	int err_count;
	int rsp_outstanding;
	int req_done = 0;
	int rsp_done = 0;
	int idle_cycles = 0;
	int settings_run = 0;
	int sender_burst = 0;
	bit sender_calm = 1'b0;
	bit held_long = 1'b0;

	// Random traffic plan: controller kind, clock present, transaction count
	logic [2:0] phase_kind [N_PHASES] = '{KIND_MBC3, KIND_MBC2, KIND_MBC1, KIND_MBC5,
		KIND_MBC3, KIND_NONE, KIND_RSVD_HI, KIND_RSVD_LO, KIND_MBC3};
	logic       phase_clock [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b1};
	int         phase_len [N_PHASES] = '{300, 200, 120, 150, 120, 60, 60, 40, 50};

	always #5 clk = ~clk;

	cartridge_bank_controller_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.addr         (addr),
		.data         (data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.handled      (handled),
		.read_data    (read_data),
		.rom_bank_out (rom_bank_out),
		.ram_bank_out (ram_bank_out),
		.ram_mapped   (ram_mapped)
	);

	cbc_rsp_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.action          (action),
		.addr            (addr),
		.data            (data),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.handled         (handled),
		.read_data       (read_data),
		.rom_bank_out    (rom_bank_out),
		.ram_bank_out    (ram_bank_out),
		.ram_mapped      (ram_mapped),
		.err_count       (err_count),
		.rsp_outstanding (rsp_outstanding)
	);

	// Transaction counters and watchdog
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (req_valid && req_ready) req_done <= req_done + 1;
		if (rsp_valid && rsp_ready) rsp_done <= rsp_done + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
	endtask

	// Both registers, with junk in the unused upper bits
	task automatic set_config(input logic [2:0] kind, input logic clock_on);
		apb_write({REG_KIND, 2'b00}, ($urandom & 32'hFFFF_FFF8) | 32'(kind));
		apb_write({REG_CLKPRES, 2'b00}, ($urandom & 32'hFFFF_FFFE) | 32'(clock_on));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_run++;
	endtask

	// Offer one request and return at the edge that accepts it; valid stays
	// high so a back-to-back transaction needs no second assignment
	task automatic send_req(input logic [1:0] a, input logic [15:0] ad, input logic [7:0] d);
		int gap;
		if (sender_burst == 0) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			sender_burst = $urandom_range(20, 80);
		end
		sender_burst--;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action <= a;
		addr <= ad;
		data <= d;
		@(negedge clk);
		while (!req_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Stop offering and wait until every predicted response has arrived
	task automatic drain_rsp();
		req_valid <= 1'b0;
		@(negedge clk);
		while (rsp_outstanding != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed mapper traffic, some pure noise
	task automatic make_random_req(output logic [1:0] a, output logic [15:0] ad,
			output logic [7:0] d);
		int pick;
		pick = $urandom_range(0, 99);
		a = 2'($urandom);
		ad = 16'($urandom);
		d = 8'($urandom);
		if (pick < 10) begin
			// RAM enable or disable, register bit 8 mostly clear for MBC2
			a = ACT_CTRL;
			ad[15:13] = 3'b000;
			if ($urandom_range(0, 3) != 0) ad[8] = 1'b0;
			if ($urandom_range(0, 4) != 0) d[3:0] = 4'hA;
		end else if (pick < 35) begin
			// bank, select and latch writes, now and then off the map
			a = ACT_CTRL;
			ad[15:13] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
				: 3'($urandom_range(1, 3));
			case ($urandom_range(0, 5))
			0: d = 8'($urandom_range(0, 3));
			1: d = 8'($urandom_range(8, 12));
			2: d = 8'($urandom_range(0, 1));
			default: ;
			endcase
		end else if (pick < 57) begin
			a = ACT_RD;
		end else if (pick < 77) begin
			a = ACT_WR;
		end else if (pick < 95) begin
			a = ACT_TICK;
		end
	endtask

	// Response side: random ready pattern, one long hold-off
	initial begin
		int on_len;
		int off_len;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_long && rsp_done >= HOLD_AFTER_RSPS) begin
				held_long = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			on_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 6);
			off_len = pick_gap();
			rsp_ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			if (off_len > 0) begin
				rsp_ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	// Main stimulus
	initial begin
		logic [1:0]  a;
		logic [15:0] ad;
		logic [7:0]  d;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		action <= ACT_CTRL;
		addr <= '0;
		data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// MBC3 with clock: day rollover with carry, field fold, latch, halt
		set_config(KIND_MBC3, 1'b1);
		send_req(ACT_RD, 16'hA000, 8'h00);
		send_req(ACT_CTRL, 16'h1FFF, 8'h1A);
		send_req(ACT_CTRL, 16'h4000, 8'h0B);
		send_req(ACT_WR, 16'hA000, 8'hFF);
		send_req(ACT_CTRL, 16'h5FFF, 8'h0C);
		send_req(ACT_WR, 16'hBFFF, 8'h01);
		send_req(ACT_CTRL, 16'h4000, 8'h0A);
		send_req(ACT_WR, 16'hA123, 8'hFF);
		send_req(ACT_TICK, 16'h0000, 8'h00);
		send_req(ACT_CTRL, 16'h6000, 8'h00);
		send_req(ACT_CTRL, 16'h7FFF, 8'h01);
		send_req(ACT_CTRL, 16'h4000, 8'h0C);
		send_req(ACT_RD, 16'hFFFF, 8'h00);
		send_req(ACT_WR, 16'hA000, 8'hC0);
		send_req(ACT_TICK, 16'hFFFF, 8'hFF);
		send_req(ACT_CTRL, 16'h2000, 8'h00);
		send_req(ACT_CTRL, 16'h3FFF, 8'hFF);
		send_req(ACT_CTRL, 16'h4000, 8'h05);
		send_req(ACT_CTRL, 16'h4000, 8'h03);
		send_req(ACT_CTRL, 16'hFFFF, 8'hFF);
		drain_rsp();

		// MBC5: bank 0 kept as 0, ninth ROM bit, wide RAM bank
		set_config(KIND_MBC5, 1'b0);
		send_req(ACT_CTRL, 16'h2000, 8'h00);
		send_req(ACT_CTRL, 16'h3000, 8'hFF);
		send_req(ACT_CTRL, 16'h5FFF, 8'hFF);
		drain_rsp();

		// MBC2: address bit 8 picks enable or ROM bank; nibble RAM top entry
		set_config(KIND_MBC2, 1'b0);
		send_req(ACT_CTRL, 16'h00FF, 8'h0A);
		send_req(ACT_CTRL, 16'h3FFF, 8'hFF);
		send_req(ACT_WR, 16'hFFFF, 8'hFF);
		send_req(ACT_RD, 16'h01FF, 8'h00);
		drain_rsp();

		// Reserved kind claims nothing
		set_config(KIND_RSVD_HI, 1'b1);
		send_req(ACT_CTRL, 16'h0000, 8'h0A);
		send_req(ACT_TICK, 16'h0000, 8'h00);

		// Random traffic, one controller setting per phase
		for (int p = 0; p < N_PHASES; p++) begin
			drain_rsp();
			set_config(phase_kind[p], phase_clock[p]);
			for (int n = 0; n < phase_len[p]; n++) begin
				make_random_req(a, ad, d);
				send_req(a, ad, d);
			end
		end
		drain_rsp();
		repeat (8) @(posedge clk);
		@(negedge clk);

		$display("testbench: %0d requests and %0d responses over %0d controller settings",
			req_done, rsp_done, settings_run);
		$display("testbench: all mapper kinds, reserved kinds, clock fold and latch, long stall");
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
